// ----- hdl/tile_pixel_fifo_mixer_macros.svh -----
// assertion macros for the pixel fifo mixer
`ifndef TILE_PIXEL_FIFO_MIXER_MACROS_SVH
`define TILE_PIXEL_FIFO_MIXER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TPFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TPFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tpfm_pkg.sv -----
// types, constants and helper functions for the pixel fifo mixer
package tpfm_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int ROW_LEN    = 8;
  localparam int ROW_IDX_W  = $clog2(ROW_LEN);
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    OP_PUSH_BG  = 2'd0,
    OP_PUSH_OBJ = 2'd1,
    OP_SHIFT    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_BG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_PALETTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_PALETTE0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_PALETTE1 = 3'd4;

  // attribute bits of the object flags byte
  localparam int FLAG_BEHIND = 7;
  localparam int FLAG_FLIP   = 5;
  localparam int FLAG_PAL    = 4;

  typedef logic [1:0] colour_t;

  typedef struct packed {
    logic [7:0] x;
    logic       behind;
    logic       pal;
    colour_t    colour;
  } obj_entry_t;

  typedef struct packed {
    logic       bg_enable;
    logic       obj_enable;
    logic [7:0] bg_palette;
    logic [7:0] obj_palette0;
    logic [7:0] obj_palette1;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] bg_count;
    logic [CNT_W-1:0] obj_count;
    logic             flip;
    logic             pal;
    logic             behind;
    logic [7:0]       x;
  } lane_ctl_t;

  // pixel 0 is leftmost, taken from bit 7 unless flipped
  function automatic colour_t pix_colour(input logic [7:0] hi, input logic [7:0] lo,
                                         input logic [ROW_IDX_W-1:0] p, input logic flip);
    logic [ROW_IDX_W-1:0] b;
    b = flip ? p : ~p;
    return {hi[b], lo[b]};
  endfunction

  function automatic logic [1:0] pal_shade(input logic [7:0] pal, input colour_t c);
    logic [1:0] s;
    case (c)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/tpfm_ifs.sv -----
// valid/ready channel interfaces for pixel ops and shaded pixels
interface tpfm_in_if
  import tpfm_pkg::*;
();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] tile_high;
  logic [7:0] tile_low;
  logic [7:0] obj_flags;
  logic [7:0] obj_x;

  modport source (output valid, output op, output tile_high, output tile_low,
                  output obj_flags, output obj_x, input ready);
  modport sink (input valid, input op, input tile_high, input tile_low,
                input obj_flags, input obj_x, output ready);
endinterface

interface tpfm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade;
  logic       from_object;

  modport source (output valid, output shade, output from_object, input ready);
  modport sink (input valid, input shade, input from_object, output ready);
endinterface

// ----- hdl/tpfm_lane.sv -----
// one fifo position: next background and object entry for the current op
module tpfm_lane
  import tpfm_pkg::*;
(
  input  logic [IDX_W-1:0] lane_idx,
  input  lane_ctl_t        ctl,
  input  logic [7:0]       tile_high,
  input  logic [7:0]       tile_low,
  input  colour_t          bg_cur,
  input  colour_t          bg_above,
  input  obj_entry_t       obj_cur,
  input  obj_entry_t       obj_above,
  output colour_t          bg_nxt,
  output obj_entry_t       obj_nxt
);

  logic [CNT_W-1:0] lane_w;
  logic [CNT_W:0]   bg_ofs;
  logic             bg_hit;
  colour_t          bg_pix;
  logic             in_row;
  logic             obj_win;
  obj_entry_t       obj_new;

  always_comb begin
    lane_w = CNT_W'(lane_idx);
    // position inside the incoming row that lands on this entry
    bg_ofs = {1'b0, lane_w} - {1'b0, ctl.bg_count};
    bg_hit = (lane_w >= ctl.bg_count) && (bg_ofs < (CNT_W + 1)'(ROW_LEN));
    bg_pix = pix_colour(tile_high, tile_low, bg_ofs[ROW_IDX_W-1:0], 1'b0);

    in_row = lane_w < CNT_W'(ROW_LEN);
    obj_new.x      = ctl.x;
    obj_new.behind = ctl.behind;
    obj_new.pal    = ctl.pal;
    obj_new.colour = pix_colour(tile_high, tile_low, lane_idx[ROW_IDX_W-1:0], ctl.flip);
    // empty slot, transparent pixel or object further right loses the slot
    obj_win = (lane_w >= ctl.obj_count) || (obj_cur.colour == 2'b00) || (obj_cur.x > ctl.x);

    bg_nxt  = bg_cur;
    obj_nxt = obj_cur;
    case (ctl.op)
      OP_PUSH_BG: begin
        if (bg_hit) bg_nxt = bg_pix;
      end
      OP_PUSH_OBJ: begin
        if (in_row && obj_win) obj_nxt = obj_new;
      end
      OP_SHIFT: begin
        if (ctl.bg_count != '0) bg_nxt = bg_above;
        if (ctl.obj_count != '0) obj_nxt = obj_above;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/tpfm_mixer.sv -----
// head-of-fifo priority and palette lookup
module tpfm_mixer
  import tpfm_pkg::*;
(
  input  cfg_t       cfg,
  input  colour_t    bg_colour,
  input  logic       obj_valid,
  input  obj_entry_t obj_head,
  output logic [1:0] shade,
  output logic       from_object
);

  logic       use_obj;
  logic [7:0] obj_pal;

  always_comb begin
    use_obj = obj_valid && cfg.obj_enable && (obj_head.colour != 2'b00) &&
              !(obj_head.behind && (bg_colour != 2'b00));
    obj_pal = obj_head.pal ? cfg.obj_palette1 : cfg.obj_palette0;
    if (use_obj) begin
      shade = pal_shade(obj_pal, obj_head.colour);
    end else if (cfg.bg_enable) begin
      shade = pal_shade(cfg.bg_palette, bg_colour);
    end else begin
      shade = 2'b00;
    end
    from_object = use_obj;
  end

endmodule

// ----- hdl/tile_pixel_fifo_mixer.sv -----
// background/object pixel fifos with per-position lanes and final pixel mixer
// latency: a shift item gives its pixel in the output register in the cycle after acceptance
// throughput: one item per cycle unless stalled; all fifo positions update in parallel lanes in that cycle
// input is stalled only while a finished pixel waits in the output register and out is not ready
// reset (synchronous, active low) clears both counts, the config registers and the output valid
// fifo storage is not cleared; entries past a count are never read
module tile_pixel_fifo_mixer
  import tpfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tpfm_in_if.sink               in_ch,
  tpfm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "tile_pixel_fifo_mixer_macros.svh"

  cfg_t             cfg_r;
  logic [CNT_W-1:0] bg_count_r, bg_count_nxt;
  logic [CNT_W-1:0] obj_count_r, obj_count_nxt;
  colour_t          bg_fifo_r  [FIFO_DEPTH];
  obj_entry_t       obj_fifo_r [FIFO_DEPTH];
  colour_t          bg_above   [FIFO_DEPTH];
  obj_entry_t       obj_above  [FIFO_DEPTH];
  colour_t          bg_nxt     [FIFO_DEPTH];
  obj_entry_t       obj_nxt    [FIFO_DEPTH];
  lane_ctl_t        ctl;
  logic             acc;
  logic [CNT_W:0]   bg_sum;
  colour_t          bg_head;
  logic [1:0]       mix_shade;
  logic             mix_from_obj;
  logic             out_valid_r;
  logic [1:0]       shade_r;
  logic             from_obj_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign ctl.op        = in_ch.op;
  assign ctl.bg_count  = bg_count_r;
  assign ctl.obj_count = obj_count_r;
  assign ctl.flip      = in_ch.obj_flags[FLAG_FLIP];
  assign ctl.pal       = in_ch.obj_flags[FLAG_PAL];
  assign ctl.behind    = in_ch.obj_flags[FLAG_BEHIND];
  assign ctl.x         = in_ch.obj_x;

  // shift source for each position; the last one keeps its own entry
  always_comb begin
    for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
      bg_above[i]  = bg_fifo_r[i+1];
      obj_above[i] = obj_fifo_r[i+1];
    end
    bg_above[FIFO_DEPTH-1]  = bg_fifo_r[FIFO_DEPTH-1];
    obj_above[FIFO_DEPTH-1] = obj_fifo_r[FIFO_DEPTH-1];
  end

  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_lane
    tpfm_lane u_lane (
      .lane_idx  (IDX_W'(i)),
      .ctl       (ctl),
      .tile_high (in_ch.tile_high),
      .tile_low  (in_ch.tile_low),
      .bg_cur    (bg_fifo_r[i]),
      .bg_above  (bg_above[i]),
      .obj_cur   (obj_fifo_r[i]),
      .obj_above (obj_above[i]),
      .bg_nxt    (bg_nxt[i]),
      .obj_nxt   (obj_nxt[i])
    );
  end

  // empty background fifo reads as colour 0
  assign bg_head = (bg_count_r != '0) ? bg_fifo_r[0] : 2'b00;

  tpfm_mixer u_mixer (
    .cfg         (cfg_r),
    .bg_colour   (bg_head),
    .obj_valid   (obj_count_r != '0),
    .obj_head    (obj_fifo_r[0]),
    .shade       (mix_shade),
    .from_object (mix_from_obj)
  );

  always_comb begin
    bg_count_nxt  = bg_count_r;
    obj_count_nxt = obj_count_r;
    bg_sum        = {1'b0, bg_count_r} + (CNT_W + 1)'(ROW_LEN);
    if (acc) begin
      case (in_ch.op)
        OP_PUSH_BG: begin
          bg_count_nxt = (bg_sum > (CNT_W + 1)'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH)
                                                               : bg_sum[CNT_W-1:0];
        end
        OP_PUSH_OBJ: begin
          if (obj_count_r < CNT_W'(ROW_LEN)) obj_count_nxt = CNT_W'(ROW_LEN);
        end
        OP_SHIFT: begin
          if (bg_count_r != '0) bg_count_nxt = bg_count_r - 1'b1;
          if (obj_count_r != '0) obj_count_nxt = obj_count_r - 1'b1;
        end
        OP_CLEAR: begin
          bg_count_nxt  = '0;
          obj_count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_count_r  <= '0;
      obj_count_r <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      bg_count_r  <= bg_count_nxt;
      obj_count_r <= obj_count_nxt;
      if (acc && (in_ch.op == OP_SHIFT)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_BG_ENABLE:    cfg_r.bg_enable    <= cfg_data[0];
          REG_OBJ_ENABLE:   cfg_r.obj_enable   <= cfg_data[0];
          REG_BG_PALETTE:   cfg_r.bg_palette   <= cfg_data;
          REG_OBJ_PALETTE0: cfg_r.obj_palette0 <= cfg_data;
          REG_OBJ_PALETTE1: cfg_r.obj_palette1 <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        bg_fifo_r[i]  <= bg_nxt[i];
        obj_fifo_r[i] <= obj_nxt[i];
      end
      if (in_ch.op == OP_SHIFT) begin
        shade_r    <= mix_shade;
        from_obj_r <= mix_from_obj;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.shade       = shade_r;
  assign out_ch.from_object = from_obj_r;

  `TPFM_ASSERT_NOW(a_count_bound, 1'b1,
    (bg_count_r <= CNT_W'(FIFO_DEPTH)) && (obj_count_r <= CNT_W'(FIFO_DEPTH)),
    "fifo count beyond depth")
  `TPFM_ASSERT_NXT(a_shift_result, acc && (in_ch.op == OP_SHIFT), out_valid_r,
    "shift item gave no pixel")
  `TPFM_ASSERT_NXT(a_obj_fill, acc && (in_ch.op == OP_PUSH_OBJ),
    obj_count_r >= CNT_W'(ROW_LEN), "object push left fifo short of a row")
  `TPFM_ASSERT_NXT(a_clear, acc && (in_ch.op == OP_CLEAR),
    (bg_count_r == '0) && (obj_count_r == '0), "clear left entries behind")

endmodule
